@@ hw/rtl/msbr_pkg.sv @@
// Shared constants for the multisample box resolve block.
package msbr_pkg;

  // Fixed field widths
  localparam int unsigned CH_W       = 8;   // one color channel
  localparam int unsigned POS_OUT_W  = 12;  // pixel_x / pixel_y on the output
  localparam int unsigned SC_W       = 5;   // sample_count register
  localparam int unsigned DIM_REG_W  = 13;  // frame_width / frame_height registers
  localparam int unsigned CFG_DATA_W = 13;  // widest register
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned IN_DATA_W  = 3 * CH_W;
  localparam int unsigned OUT_DATA_W = 3 * CH_W + 2 * POS_OUT_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [SC_W-1:0]      SAMPLE_COUNT_RST = 5'd4;
  localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

endpackage

@@ hw/rtl/msbr_front.sv @@
// Front end: config registers, per-pixel sample accumulation and pixel position.
module msbr_front #(
  parameter int unsigned MAX_SAMPLES = 16,
  parameter int unsigned MAX_DIM     = 4096,
  parameter int unsigned ENTRY_W     = 79
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [msbr_pkg::IN_DATA_W-1:0]   s_data_i,
  input  logic                             full_i,
  output logic                             push_o,
  output logic [ENTRY_W-1:0]               entry_o
);
  import msbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = $clog2(255 * MAX_SAMPLES + 1);
  localparam int unsigned POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  logic [SC_W-1:0]      sample_count_q;
  logic [DIM_REG_W-1:0] frame_width_q, frame_height_q;
  logic [CNT_W-1:0]     idx_q;
  logic [2:0][SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0]     col_q, row_q;

  logic [CNT_W-1:0] cnt_eff;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             fire, pixel_done, last_row, last_col;

  // Effective settings: zero acts as one, large values saturate
  always_comb begin
    if (sample_count_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (32'(sample_count_q) > 32'(MAX_SAMPLES)) begin
      cnt_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      cnt_eff = CNT_W'(sample_count_q);
    end
    if (frame_width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(frame_width_q) > 32'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(frame_height_q) > 32'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(frame_height_q);
    end
  end

  assign s_ready_o  = !full_i;
  assign fire       = s_valid_i && s_ready_o;
  assign pixel_done = ({1'b0, idx_q} + (CNT_W+1)'(1)) >= {1'b0, cnt_eff};
  assign last_row   = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
  assign last_col   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = sum_q[c] + SUM_W'(s_data_i[c*CH_W +: CH_W]);
    end
  end

  assign push_o  = fire && pixel_done;
  // {frame_end, y, x, count, red, green, blue sums}
  assign entry_o = {last_row && last_col, POS_OUT_W'(row_q), POS_OUT_W'(col_q), cnt_eff,
                    sum_d[2], sum_d[1], sum_d[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      idx_q          <= '0;
      sum_q          <= '0;
      col_q          <= '0;
      row_q          <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SAMPLE_COUNT) begin
        sample_count_q <= cfg_data_i[SC_W-1:0];
        idx_q          <= '0;   // restart pixel in progress
        sum_q          <= '0;
      end else if (fire) begin
        if (pixel_done) begin
          idx_q <= '0;
          sum_q <= '0;
          if (last_row) begin
            row_q <= '0;
            col_q <= last_col ? '0 : col_q + POS_W'(1);
          end else begin
            row_q <= row_q + POS_W'(1);
          end
        end else begin
          idx_q <= idx_q + CNT_W'(1);
          sum_q <= sum_d;
        end
      end
      if (cfg_we_i && cfg_idx_i == CFG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[DIM_REG_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[DIM_REG_W-1:0];
      end
    end
  end

  a_idx_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < cnt_eff)
    else $error("sample index reached sample count");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q[0] <= SUM_W'(idx_q) * SUM_W'(255) &&
    sum_q[1] <= SUM_W'(idx_q) * SUM_W'(255) &&
    sum_q[2] <= SUM_W'(idx_q) * SUM_W'(255))
    else $error("running sum exceeds samples taken");

endmodule

@@ hw/rtl/msbr_fifo.sv @@
// Small register queue between the accumulator and the divider.
module msbr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overrun or underrun");

endmodule

@@ hw/rtl/msbr_back.sv @@
// Back end: shift-subtract divider for the three channels plus output register.
module msbr_back #(
  parameter int unsigned MAX_SAMPLES = 16,
  parameter int unsigned ENTRY_W     = 79
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  logic [ENTRY_W-1:0]               entry_i,
  output logic                             pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [msbr_pkg::OUT_DATA_W-1:0]  m_data_o,
  output logic                             m_last_o
);
  import msbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = $clog2(255 * MAX_SAMPLES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q;
  logic [2:0]            step_q;
  logic [2:0][SUM_W-1:0] rem_q;
  logic [2:0][CH_W-1:0]  quo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [POS_OUT_W-1:0]  x_q, y_q;
  logic                  last_q;
  logic                  out_valid_q, out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [SUM_W-1:0]      div_d;
  logic [2:0]            ge;
  logic                  load_out;

  // Quotient fits 8 bits since each sum is at most 255 * count
  assign div_d = SUM_W'(cnt_q) << step_q;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ge[c] = rem_q[c] >= div_d;
    end
  end

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= ST_DIV;
            step_q  <= 3'd7;
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q - 3'd1;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {last_q, y_q, x_q, cnt_q, rem_q[2], rem_q[1], rem_q[0]} <= entry_i;
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      for (int c = 0; c < 3; c++) begin
        if (ge[c]) begin
          rem_q[c] <= rem_q[c] - div_d;
        end
        quo_q[c] <= {quo_q[c][CH_W-2:0], ge[c]};
      end
    end
    if (load_out) begin
      out_data_q <= {y_q, x_q, quo_q[2], quo_q[1], quo_q[0]};
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |->
      ((SUM_W+1)'(rem_q[0]) < ((SUM_W+1)'(cnt_q) << (4'(step_q) + 4'd1)) &&
       (SUM_W+1)'(rem_q[1]) < ((SUM_W+1)'(cnt_q) << (4'(step_q) + 4'd1)) &&
       (SUM_W+1)'(rem_q[2]) < ((SUM_W+1)'(cnt_q) << (4'(step_q) + 4'd1))))
    else $error("divider remainder out of range");

endmodule

@@ hw/rtl/multisample_box_resolve_unit.sv @@
// Top level of the multisample box resolve: front accumulator, queue, back divider.
// Accepts one sample per cycle while the pixel queue has room.
// A pixel's result passes through the queue pop, an eight-step shift-subtract divide
//   and the output register after its last sample is taken.
// The divider takes a new pixel only once it has finished the last one;
//   the two-entry queue absorbs a pixel while the divider is busy.
// Reset (rst_ni low, asynchronous): registers to 4 / 640 / 480, sums, sample index
//   and position to zero, queue and output empty; no clearing pass.
module multisample_box_resolve_unit #(
  parameter int unsigned MAX_SAMPLES = 16,   // 1..64
  parameter int unsigned MAX_DIM     = 4096  // 16..4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Config write port
  input  logic                             cfg_we_i,
  input  logic [msbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [msbr_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // blue_sample, green_sample, red_sample
  // Pixel stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [msbr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // blue_avg, green_avg, red_avg,
                                                          // pixel_x, pixel_y
  output logic                             m_axis_tlast   // frame_end
);
  import msbr_pkg::*;

  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W       = $clog2(255 * MAX_SAMPLES + 1);
  // {frame_end, y, x, count, three sums}
  localparam int unsigned ENTRY_W     = 1 + 2 * POS_OUT_W + CNT_W + 3 * SUM_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Accumulate samples into pixels, track position
  msbr_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_DIM     (MAX_DIM),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  // Decouples sample intake from the divider
  msbr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Divide sums by count, register result
  msbr_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .entry_i   (q_rdata),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule
